[design/csm_pkg.sv]
package csm_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // floor(x/3) == (x*683) >> 11 for x <= 765
  localparam logic [9:0] LEVEL_RECIP = 10'd683;
  localparam logic [7:0] FULL_SCALE  = 8'd255;
  localparam logic [2:0] DIV_LAST    = 3'd7;

  typedef enum logic {
    REQ_MEASURE = 1'b0,
    REQ_APPLY   = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    CH_ZERO = 2'd0,
    CH_FULL = 2'd1,
    CH_DIV  = 2'd2
  } ch_mode_t;

  typedef enum logic [1:0] {
    BACK_IDLE = 2'd0,
    BACK_DIV  = 2'd1,
    BACK_DONE = 2'd2
  } back_state_t;

  typedef struct packed {
    logic       req_type;
    logic       first_of_frame;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } csm_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       range_zero;
  } csm_out_t;

  // one channel's divide job: partial remainder and remaining dividend bits
  typedef struct packed {
    ch_mode_t   mode;
    logic [7:0] rem;
    logic [7:0] low;
  } csm_chan_t;

  // lane 0 blue, 1 green, 2 red
  typedef struct packed {
    csm_chan_t [2:0] chan;
    logic [7:0]      den;
    logic            range_zero;
  } csm_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } csm_qstat_t;

endpackage

[design/contrast_stretch_minmax.sv]
// Channel   Direction  Handshake          Payload
// request   in         push / full        din  (req_type, first_of_frame, blue/green/red_in)
// result    out        pop  / empty       dout (blue/green/red_out, range_zero)
//
// A measure pixel is absorbed in the cycle it is accepted; it yields no result.
// An apply pixel passes through the back end as a load, 8 divide steps of the
// bit-serial divider and a write to the output register.
// Up to 4 apply pixels wait in the queue between front and back, so push
// stalls only when that queue is full. Reset (rst, synchronous) sets darkest
// to 255 and brightest to 0 and empties the queue and output register.
module contrast_stretch_minmax (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  csm_pkg::csm_in_t   din,
  output logic               empty,
  input  logic               pop,
  output csm_pkg::csm_out_t  dout
);

  logic                 take;
  logic                 q_wr;
  logic                 q_rd;
  logic                 out_valid;
  csm_pkg::csm_job_t    q_wdata;
  csm_pkg::csm_job_t    q_rdata;
  csm_pkg::csm_qstat_t  q_stat;

  // any request is held off while the queue is full, measure pixels too,
  // so full never depends on the payload
  assign full  = q_stat.full;
  assign take  = push && !full;
  assign empty = !out_valid;

  // front: level tracking on measure pixels, channel classification and
  // level snapshot on apply pixels
  csm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .din      (din),
    .job_push (q_wr),
    .job      (q_wdata)
  );

  csm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: per-channel divide of 255*(c-darkest) by (brightest-darkest)
  csm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (q_stat),
    .job       (q_rdata),
    .job_pop   (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .dout      (dout)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_stat.full)
    else $error("queue written while full");

  // back end never takes from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_stat.empty)
    else $error("queue read while empty");

  // an empty range gives all-zero channels
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && dout.range_zero) |->
      (dout.blue_out == 8'd0 && dout.green_out == 8'd0 && dout.red_out == 8'd0))
    else $error("range_zero result with nonzero channel");

  // an unpopped result is not overwritten by the next one
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("pending result lost");

endmodule

[design/csm_front.sv]
module csm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  csm_pkg::csm_in_t    din,
  output logic                job_push,
  output csm_pkg::csm_job_t   job
);

  logic [7:0]  darkest;
  logic [7:0]  brightest;
  logic [7:0]  darkest_next;
  logic [7:0]  brightest_next;
  logic [9:0]  sum;
  logic [19:0] prod;
  logic [7:0]  level;
  logic        range_zero;
  logic [7:0]  pix [3];

  function automatic csm_pkg::csm_chan_t classify(input logic [7:0] c,
                                                  input logic [7:0] lo,
                                                  input logic [7:0] hi,
                                                  input logic       rz);
    csm_pkg::csm_chan_t r;
    logic [7:0]  diff;
    logic [15:0] num;
    diff   = c - lo;
    num    = {diff, 8'd0} - {8'd0, diff};
    r.rem  = num[15:8];
    r.low  = num[7:0];
    if (rz || c <= lo) begin
      r.mode = csm_pkg::CH_ZERO;
    end else if (c >= hi) begin
      r.mode = csm_pkg::CH_FULL;
    end else begin
      r.mode = csm_pkg::CH_DIV;
    end
    return r;
  endfunction

  assign sum   = {2'd0, din.blue_in} + {2'd0, din.green_in} + {2'd0, din.red_in};
  assign prod  = sum * csm_pkg::LEVEL_RECIP;
  assign level = prod[18:11];

  always_comb begin
    darkest_next   = darkest;
    brightest_next = brightest;
    if (take && din.req_type == csm_pkg::REQ_MEASURE) begin
      if (din.first_of_frame) begin
        darkest_next   = level;
        brightest_next = level;
      end else begin
        if (level < darkest)   darkest_next   = level;
        if (level > brightest) brightest_next = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      darkest   <= csm_pkg::FULL_SCALE;
      brightest <= '0;
    end else begin
      darkest   <= darkest_next;
      brightest <= brightest_next;
    end
  end

  // apply pixels carry a snapshot of the levels into the queue
  assign range_zero = (brightest <= darkest);
  assign pix[0]     = din.blue_in;
  assign pix[1]     = din.green_in;
  assign pix[2]     = din.red_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job.chan[i] = classify(pix[i], darkest, brightest, range_zero);
    end
    job.den        = brightest - darkest;
    job.range_zero = range_zero;
  end

  assign job_push = take && din.req_type == csm_pkg::REQ_APPLY;

endmodule

[design/csm_queue.sv]
module csm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  csm_pkg::csm_job_t    wdata,
  input  logic                 rd,
  output csm_pkg::csm_job_t    rdata,
  output csm_pkg::csm_qstat_t  stat
);

  csm_pkg::csm_job_t             slots [csm_pkg::QUEUE_DEPTH];
  logic [csm_pkg::QPTR_W-1:0]    wptr;
  logic [csm_pkg::QPTR_W-1:0]    rptr;
  logic [csm_pkg::QCNT_W-1:0]    count;

  assign stat.full  = (count == csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/csm_back.sv]
module csm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  csm_pkg::csm_qstat_t  qstat,
  input  csm_pkg::csm_job_t    job,
  output logic                 job_pop,
  input  logic                 pop,
  output logic                 out_valid,
  output csm_pkg::csm_out_t    dout
);

  csm_pkg::back_state_t state;
  csm_pkg::back_state_t state_next;
  logic                 load;
  logic                 step;
  logic                 emit;
  logic [2:0]           cnt;
  logic [7:0]           den;
  logic                 range_zero;
  csm_pkg::ch_mode_t    mode [3];
  logic [7:0]           rem  [3];
  logic [7:0]           low  [3];
  logic [7:0]           quo  [3];
  logic [7:0]           res  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csm_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    step       = 1'b0;
    emit       = 1'b0;
    case (state)
      csm_pkg::BACK_IDLE: begin
        if (!qstat.empty) begin
          load       = 1'b1;
          state_next = csm_pkg::BACK_DIV;
        end
      end
      csm_pkg::BACK_DIV: begin
        step = 1'b1;
        if (cnt == csm_pkg::DIV_LAST) state_next = csm_pkg::BACK_DONE;
      end
      csm_pkg::BACK_DONE: begin
        if (!out_valid || pop) begin
          emit       = 1'b1;
          state_next = csm_pkg::BACK_IDLE;
        end
      end
      default: state_next = csm_pkg::BACK_IDLE;
    endcase
  end

  assign job_pop = load;

  // restoring divide, one quotient bit per lane per cycle
  always_ff @(posedge clk) begin
    logic [8:0] t;
    if (load) begin
      cnt        <= '0;
      den        <= job.den;
      range_zero <= job.range_zero;
      for (int i = 0; i < 3; i++) begin
        mode[i] <= job.chan[i].mode;
        rem[i]  <= job.chan[i].rem;
        low[i]  <= job.chan[i].low;
        quo[i]  <= '0;
      end
    end else if (step) begin
      cnt <= cnt + 1'b1;
      for (int i = 0; i < 3; i++) begin
        t = {rem[i], low[i][7]};
        if (t >= {1'b0, den}) begin
          t      = t - {1'b0, den};
          quo[i] <= {quo[i][6:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][6:0], 1'b0};
        end
        rem[i] <= t[7:0];
        low[i] <= {low[i][6:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (mode[i])
        csm_pkg::CH_FULL: res[i] = csm_pkg::FULL_SCALE;
        csm_pkg::CH_DIV:  res[i] = quo[i];
        default:          res[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dout.blue_out   <= res[0];
      dout.green_out  <= res[1];
      dout.red_out    <= res[2];
      dout.range_zero <= range_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[bench/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // no-progress window before declaring a hang; it covers an apply pixel's pass
  // through the back end plus sender gaps and receiver stalls
  localparam int HANG_LIMIT  = 4000;
  // tail after the last expected result, well above the back-end latency
  localparam int DRAIN_TAIL  = 40;
  localparam int RAND_PIXELS = 1250;
  localparam int QUIET_TAIL  = 120;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  csm_pkg::csm_in_t  din = '0;
  logic              empty;
  logic              pop = 1'b0;
  csm_pkg::csm_out_t dout;

  always #5 clk = ~clk;

  contrast_stretch_minmax i_dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (din),
    .empty(empty),
    .pop  (pop),
    .dout (dout)
  );

  // pixels waiting to be pushed, and stretched pixels still owed by the block
  csm_pkg::csm_in_t  pixel_q[$];
  csm_pkg::csm_out_t stretched_q[$];

  // predicted tracking state, snapshot at acceptance time
  logic [7:0] dark_lvl = 8'd255;
  logic [7:0] bright_lvl = 8'd0;

  int mismatches = 0;
  int stall_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int phase_cnt = 0;
  bit calm = 1'b0;
  bit quiet = 1'b0;

  // 255*(c-lo)/(hi-lo), truncated toward zero, clamped to 0..255
  function automatic logic [7:0] stretch_level(logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
    int num;
    int den;
    int q;
    num = int'(csm_pkg::FULL_SCALE) * (int'(c) - int'(lo));
    den = int'(hi) - int'(lo);
    q = num / den;
    if (q < 0) q = 0;
    if (q > int'(csm_pkg::FULL_SCALE)) q = int'(csm_pkg::FULL_SCALE);
    return q[7:0];
  endfunction

  // measure pixels move the levels; apply pixels owe one stretched result
  task automatic track_and_stretch(csm_pkg::csm_in_t px);
    int level;
    csm_pkg::csm_out_t res;
    if (px.req_type == csm_pkg::REQ_MEASURE) begin
      level = (int'(px.blue_in) + int'(px.green_in) + int'(px.red_in)) / 3;
      if (px.first_of_frame) begin
        dark_lvl = level[7:0];
        bright_lvl = level[7:0];
      end else begin
        if (level[7:0] < dark_lvl) dark_lvl = level[7:0];
        if (level[7:0] > bright_lvl) bright_lvl = level[7:0];
      end
    end else begin
      res = '0;
      if (bright_lvl <= dark_lvl) begin
        res.range_zero = 1'b1;
      end else begin
        res.blue_out = stretch_level(px.blue_in, dark_lvl, bright_lvl);
        res.green_out = stretch_level(px.green_in, dark_lvl, bright_lvl);
        res.red_out = stretch_level(px.red_in, dark_lvl, bright_lvl);
      end
      stretched_q.push_back(res);
    end
  endtask

  task automatic queue_pixel(csm_pkg::req_kind_t kind, logic mark, int b, int g, int r);
    csm_pkg::csm_in_t px;
    px.req_type = kind;
    px.first_of_frame = mark;
    px.blue_in = b[7:0];
    px.green_in = g[7:0];
    px.red_in = r[7:0];
    pixel_q.push_back(px);
  endtask

  // Driver: inputs move on the falling edge. Idle bursts on either side are
  // switched off in calm stretches and near the end of the run.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      phase_cnt++;
      if (phase_cnt % 256 == 0) calm = ($urandom_range(0, 3) == 0);
      quiet = calm || (pixel_q.size() < QUIET_TAIL);

      if (in_gap == 0 && !quiet && $urandom_range(0, 12) == 0) in_gap = $urandom_range(1, 11);
      push <= (in_gap == 0) && (pixel_q.size() > 0);
      if (pixel_q.size() > 0) din <= pixel_q[0];
      if (in_gap > 0) in_gap--;

      if (out_gap == 0 && !quiet && $urandom_range(0, 12) == 0) out_gap = $urandom_range(1, 11);
      pop <= (out_gap == 0);
      if (out_gap > 0) out_gap--;
    end
  end

  // Monitor: both handshakes sampled on the rising edge; also the hang watchdog.
  always @(posedge clk) begin
    bit took_req;
    bit took_res;
    csm_pkg::csm_out_t want;
    took_req = 1'b0;
    took_res = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        took_req = 1'b1;
        track_and_stretch(din);
        void'(pixel_q.pop_front());
      end
      if (pop && !empty) begin
        took_res = 1'b1;
        if (stretched_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: b=%0d g=%0d r=%0d rz=%0b",
                     dout.blue_out, dout.green_out, dout.red_out, dout.range_zero);
        end else begin
          want = stretched_q.pop_front();
          if (dout.blue_out !== want.blue_out || dout.green_out !== want.green_out ||
              dout.red_out !== want.red_out || dout.range_zero !== want.range_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp b=%0d g=%0d r=%0d rz=%0b, got b=%0d g=%0d r=%0d rz=%0b",
                       want.blue_out, want.green_out, want.red_out, want.range_zero,
                       dout.blue_out, dout.green_out, dout.red_out, dout.range_zero);
          end
        end
      end
      if (took_req || took_res) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= HANG_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", HANG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int pick;
    int base;
    int spread;
    int top;
    int n_meas;
    int n_apply;
    bit broken;

    // --- directed ---
    // apply before any measure: levels still at reset, range is empty
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 0, 0, 0);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b1, 255, 255, 255);
    // full-scale range 0..255
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b1, 0, 0, 0);
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b0, 255, 255, 255);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 0, 0, 0);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 255, 255, 255);
    // mark on an apply pixel must not restart tracking
    queue_pixel(csm_pkg::REQ_APPLY, 1'b1, 128, 64, 200);
    // restart to 100..200, then values below and above the range
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b1, 100, 100, 101);
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b0, 200, 201, 199);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 50, 100, 250);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 150, 199, 101);
    // single measure pixel: dark == bright, empty range
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b1, 10, 20, 31);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 20, 0, 255);
    // truncated average (2/3 -> 0) widens the range downward
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b0, 1, 1, 0);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 7, 13, 19);
    // range of one level: nearly everything clamps
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b1, 100, 101, 102);
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b0, 102, 102, 102);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 101, 102, 255);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 0, 255, 103);
    // top of the scale
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b1, 255, 255, 254);
    queue_pixel(csm_pkg::REQ_MEASURE, 1'b0, 255, 255, 255);
    queue_pixel(csm_pkg::REQ_APPLY, 1'b0, 254, 255, 0);

    // --- random frames: measure burst then apply burst, plus some noise ---
    n = 0;
    while (n < RAND_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // noise: any mix of kinds and marks
        repeat ($urandom_range(1, 6)) begin
          queue_pixel(csm_pkg::req_kind_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
          n++;
        end
      end else begin
        broken = (pick == 1);  // frame without a restart mark keeps old levels
        base = $urandom_range(0, 255);
        case ($urandom_range(0, 3))
          0: spread = 0;
          1: spread = $urandom_range(1, 3);
          2: spread = $urandom_range(4, 40);
          default: spread = 255;
        endcase
        top = (base + spread > 255) ? 255 : base + spread;
        n_meas = $urandom_range(1, 8);
        n_apply = $urandom_range(1, 10);
        for (int i = 0; i < n_meas; i++) begin
          queue_pixel(csm_pkg::REQ_MEASURE, (i == 0) && !broken, $urandom_range(base, top),
                      $urandom_range(base, top), $urandom_range(base, top));
          n++;
        end
        for (int i = 0; i < n_apply; i++) begin
          if ($urandom_range(0, 1))
            queue_pixel(csm_pkg::REQ_APPLY, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
          else
            queue_pixel(csm_pkg::REQ_APPLY, 1'($urandom_range(0, 1)),
                        $urandom_range(base, top), $urandom_range(base, top),
                        $urandom_range(base, top));
          n++;
        end
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (pixel_q.size() > 0 || stretched_q.size() > 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
